>>> rtl/bld_pkg.sv
// Shared types and constants for the packed BCD long divider.
`default_nettype none

package bld_pkg;

    localparam int DIVIDEND_W  = 32;
    localparam int DIVISOR_W   = 16;
    localparam int QUOTIENT_W  = 32;
    localparam int REMAINDER_W = 16;
    localparam int STATUS_W    = 2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_DIGIT = 2'd2;

    localparam logic [3:0] DIGIT_MAX = 4'd9;
    localparam logic [4:0] RADIX     = 5'd10;

    typedef struct packed {
        logic [DIVIDEND_W-1:0] dividend_bcd;
        logic [DIVISOR_W-1:0]  divisor_bcd;
    } bld_req_t;

    typedef struct packed {
        logic [QUOTIENT_W-1:0]  quotient_bcd;
        logic [REMAINDER_W-1:0] remainder_bcd;
        logic [STATUS_W-1:0]    status;
    } bld_rsp_t;

endpackage

`default_nettype wire

>>> rtl/bld_check.sv
// Operand screening: flags nibbles above nine and a zero divisor.
`default_nettype none

module bld_check #(
    parameter int DD_DIGITS = 8,
    parameter int DV_DIGITS = 4
) (
    input  wire logic [4*DD_DIGITS-1:0] dividend,
    input  wire logic [4*DV_DIGITS-1:0] divisor,
    output logic [bld_pkg::STATUS_W-1:0] status
);

    logic bad;

    always_comb
    begin
        bad = 1'b0;
        for (int k = 0; k < DD_DIGITS; k++)
        begin
            if (dividend[4*k +: 4] > bld_pkg::DIGIT_MAX)
            begin
                bad = 1'b1;
            end
        end
        for (int k = 0; k < DV_DIGITS; k++)
        begin
            if (divisor[4*k +: 4] > bld_pkg::DIGIT_MAX)
            begin
                bad = 1'b1;
            end
        end
        // An invalid digit takes priority over a zero divisor.
        if (bad)
        begin
            status = bld_pkg::ST_BAD_DIGIT;
        end
        else if (divisor == '0)
        begin
            status = bld_pkg::ST_DIV_ZERO;
        end
        else
        begin
            status = bld_pkg::ST_OK;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bld_bcd_sub.sv
// Shared BCD subtractor: a minus b, digit by digit with borrow.
`default_nettype none

module bld_bcd_sub #(
    parameter int DIGITS = 5
) (
    input  wire logic [4*DIGITS-1:0] a,
    input  wire logic [4*DIGITS-1:0] b,
    output logic [4*DIGITS-1:0]      diff,
    output logic                     borrow
);

    logic       carry;
    logic [4:0] t;

    always_comb
    begin
        carry = 1'b0;
        t     = '0;
        diff  = '0;
        for (int k = 0; k < DIGITS; k++)
        begin
            t = {1'b0, a[4*k +: 4]} - {1'b0, b[4*k +: 4]} - {4'd0, carry};
            // A negative digit result wraps back into 0..9 and borrows.
            if (t[4])
            begin
                t     = t + bld_pkg::RADIX;
                carry = 1'b1;
            end
            else
            begin
                carry = 1'b0;
            end
            diff[4*k +: 4] = t[3:0];
        end
        borrow = carry;
    end

endmodule

`default_nettype wire

>>> rtl/bcd_long_divider.sv
// Packed BCD restoring long divider with a shared BCD subtractor and a small sequencer.
//
//   channel | dir | handshake               | payload
//   --------+-----+-------------------------+----------------------------------------
//   req     | in  | req_valid / req_ready   | dividend_bcd, divisor_bcd
//   rsp     | out | rsp_valid / rsp_ready   | quotient_bcd, remainder_bcd, status
//
// After acceptance S_SHIFT brings down each dividend digit, then S_SUB runs trial
// subtractions, one at a time, until one borrows or the digit reaches nine; the count of
// successful trials is that quotient digit. The single BCD subtractor is used once per
// trial subtraction. Invalid operands and a zero divisor go straight to S_DONE.
// req_ready is high only while the sequencer is idle; a finished result moves to the
// output register, so a new transaction may enter while rsp waits on rsp_ready.
// Reset clears the sequencer and rsp_valid; no clearing pass is needed.
`default_nettype none

module bcd_long_divider #(
    parameter int DIVIDEND_DIGITS = 8,
    parameter int DIVISOR_DIGITS  = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire bld_pkg::bld_req_t req,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output bld_pkg::bld_rsp_t     rsp
);

    // Divisor digits that can be nonzero, and partial remainder digits (one more).
    localparam int DV  = (DIVISOR_DIGITS < 4) ? DIVISOR_DIGITS : 4;
    localparam int PD  = DV + 1;
    localparam int DW  = 4 * DIVIDEND_DIGITS;
    localparam int CW  = $clog2(DIVIDEND_DIGITS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_SUB   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [3:0]                    qd_reg, qd_next;
    logic [DW-1:0]                 dvd_reg, dvd_next;
    logic [4*DV-1:0]               dvs_reg, dvs_next;
    logic [4*PD-1:0]               part_reg, part_next;
    logic [bld_pkg::QUOTIENT_W-1:0] quot_reg, quot_next;
    logic [bld_pkg::STATUS_W-1:0]  stat_reg, stat_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    bld_pkg::bld_rsp_t             rsp_reg, rsp_next;

    logic [DW+bld_pkg::DIVIDEND_W-1:0] dvd_ext;
    logic [DW-1:0]                 dvd_in;
    logic [4*DV-1:0]               dvs_in;
    logic [bld_pkg::STATUS_W-1:0]  chk_status;
    logic [4*PD-1:0]               sub_diff;
    logic                          sub_borrow;
    logic                          take;

    // Dividend digits beyond the field width read as zero.
    assign dvd_ext = {{DW{1'b0}}, req.dividend_bcd};
    assign dvd_in  = dvd_ext[DW-1:0];
    assign dvs_in  = req.divisor_bcd[4*DV-1:0];

    bld_check #(
        .DD_DIGITS (DIVIDEND_DIGITS),
        .DV_DIGITS (DV)
    ) u_check (
        .dividend (dvd_in),
        .divisor  (dvs_in),
        .status   (chk_status)
    );

    bld_bcd_sub #(
        .DIGITS (PD)
    ) u_sub (
        .a      (part_reg),
        .b      ({4'd0, dvs_reg}),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    assign take      = !sub_borrow && (qd_reg != bld_pkg::DIGIT_MAX);
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        qd_next        = qd_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        part_next      = part_reg;
        quot_next      = quot_reg;
        stat_next      = stat_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    dvd_next  = dvd_in;
                    dvs_next  = dvs_in;
                    part_next = '0;
                    quot_next = '0;
                    qd_next   = '0;
                    cnt_next  = CW'(DIVIDEND_DIGITS);
                    stat_next = chk_status;
                    state_next = (chk_status == bld_pkg::ST_OK) ? S_SHIFT : S_DONE;
                end
            end
            S_SHIFT:
            begin
                // Bring down the next dividend digit: partial times ten plus digit.
                part_next = {part_reg[4*PD-5:0], dvd_reg[DW-1 -: 4]};
                dvd_next  = dvd_reg << 4;
                qd_next   = '0;
                state_next = S_SUB;
            end
            S_SUB:
            begin
                if (take)
                begin
                    part_next = sub_diff;
                    qd_next   = qd_reg + 4'd1;
                end
                else
                begin
                    // The failed trial is simply not committed, which restores the partial.
                    quot_next = {quot_reg[bld_pkg::QUOTIENT_W-5:0], qd_reg};
                    if (cnt_reg == CW'(1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - CW'(1);
                        state_next = S_SHIFT;
                    end
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.quotient_bcd  = quot_reg;
                    rsp_next.remainder_bcd = bld_pkg::REMAINDER_W'(part_reg);
                    rsp_next.status        = stat_reg;
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        qd_reg   <= qd_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        part_reg <= part_next;
        quot_reg <= quot_next;
        stat_reg <= stat_next;
        rsp_reg  <= rsp_next;
    end

endmodule

`default_nettype wire

>>> rtl/bld_checker.sv
// Port-level assertions for the BCD long divider, bound to the top level.
`default_nettype none

module bld_props (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire bld_pkg::bld_req_t req,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire bld_pkg::bld_rsp_t rsp
);

    // A stalled result holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // The divider is busy in the cycle after it takes a transaction.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("divider ready right after accepting a transaction");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == bld_pkg::ST_OK) || (rsp.status == bld_pkg::ST_DIV_ZERO)
                      || (rsp.status == bld_pkg::ST_BAD_DIGIT))
        else $error("unknown status code");

    // Flagged operands give zero quotient and remainder.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != bld_pkg::ST_OK)
            |-> (rsp.quotient_bcd == '0) && (rsp.remainder_bcd == '0))
        else $error("nonzero result on a flagged transaction");

    a_rem_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.remainder_bcd[3:0] <= bld_pkg::DIGIT_MAX)
                   && (rsp.remainder_bcd[7:4] <= bld_pkg::DIGIT_MAX)
                   && (rsp.remainder_bcd[11:8] <= bld_pkg::DIGIT_MAX)
                   && (rsp.remainder_bcd[15:12] <= bld_pkg::DIGIT_MAX))
        else $error("remainder holds a nibble above nine");

endmodule

bind bcd_long_divider bld_props u_bld_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

>>> verif/bld_checker.sv
// Checker for the BCD long divider: predicts each division and compares every result.
module bld_checker
    import bld_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_ready,
    input  bld_req_t req,
    input  logic     rsp_valid,
    input  logic     rsp_ready,
    input  bld_rsp_t rsp,
    output int       mismatches,
    output int       outstanding
);

    localparam int DVD_DIGITS = DIVIDEND_W / 4;
    localparam int DVS_DIGITS = DIVISOR_W / 4;
    localparam int REM_DIGITS = REMAINDER_W / 4;

    bld_rsp_t pending_results[$];
    bld_rsp_t want;
    int       fail_cnt = 0;

    // Restoring decimal long division, one quotient digit per dividend digit.
    function automatic bld_rsp_t bcd_divide(input bld_req_t op);
        bld_rsp_t    res;
        bit          bad_digit;
        int unsigned dvs_val;
        int unsigned partial;
        int unsigned qd;
        res       = '0;
        bad_digit = 1'b0;
        for (int k = 0; k < DVD_DIGITS; k++)
            if (op.dividend_bcd[4*k +: 4] > DIGIT_MAX)
                bad_digit = 1'b1;
        for (int k = 0; k < DVS_DIGITS; k++)
            if (op.divisor_bcd[4*k +: 4] > DIGIT_MAX)
                bad_digit = 1'b1;
        if (bad_digit)
        begin
            res.status = ST_BAD_DIGIT;
            return res;
        end
        dvs_val = 0;
        for (int k = DVS_DIGITS - 1; k >= 0; k--)
            dvs_val = dvs_val * int'(RADIX) + op.divisor_bcd[4*k +: 4];
        if (dvs_val == 0)
        begin
            res.status = ST_DIV_ZERO;
            return res;
        end
        partial = 0;
        for (int k = DVD_DIGITS - 1; k >= 0; k--)
        begin
            partial = partial * int'(RADIX) + op.dividend_bcd[4*k +: 4];
            qd = 0;
            while (partial >= dvs_val)
            begin
                partial = partial - dvs_val;
                qd++;
            end
            res.quotient_bcd[4*k +: 4] = qd[3:0];
        end
        for (int k = 0; k < REM_DIGITS; k++)
        begin
            res.remainder_bcd[4*k +: 4] = 4'(partial % int'(RADIX));
            partial = partial / int'(RADIX);
        end
        res.status = ST_OK;
        return res;
    endfunction

    // A result can never leave in the cycle its request arrives, so the pop goes first.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
            begin
                if (pending_results.size() == 0)
                begin
                    fail_cnt++;
                    $display("%0t: unexpected transaction, quotient %h remainder %h status %0d",
                             $time, rsp.quotient_bcd, rsp.remainder_bcd, rsp.status);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.quotient_bcd !== want.quotient_bcd)
                    begin
                        fail_cnt++;
                        $display("%0t: quotient expected %h, got %h",
                                 $time, want.quotient_bcd, rsp.quotient_bcd);
                    end
                    if (rsp.remainder_bcd !== want.remainder_bcd)
                    begin
                        fail_cnt++;
                        $display("%0t: remainder expected %h, got %h",
                                 $time, want.remainder_bcd, rsp.remainder_bcd);
                    end
                    if (rsp.status !== want.status)
                    begin
                        fail_cnt++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, rsp.status);
                    end
                end
            end
            if (req_valid === 1'b1 && req_ready === 1'b1)
                pending_results.push_back(bcd_divide(req));
        end
        mismatches  <= fail_cnt;
        outstanding <= pending_results.size();
    end

endmodule

>>> verif/testbench.sv
// Top of the BCD long divider testbench: clock, reset, stimulus and verdict.
module testbench;

    import bld_pkg::*;

    localparam int RANDOM_ITEMS = 700;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    bld_req_t req;
    logic     rsp_valid;
    logic     rsp_ready;
    bld_rsp_t rsp;
    logic     long_hold;
    int       mismatches;
    int       outstanding;

    bcd_long_divider u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    bld_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    function automatic bld_req_t operands(input logic [DIVIDEND_W-1:0] dvd,
                                          input logic [DIVISOR_W-1:0] dvs);
        bld_req_t op;
        op.dividend_bcd = dvd;
        op.divisor_bcd  = dvs;
        return op;
    endfunction

    function automatic logic [31:0] rand_bcd(input int digits);
        logic [31:0] v;
        v = '0;
        for (int k = 0; k < digits; k++)
            v[4*k +: 4] = 4'($urandom_range(9));
        return v;
    endfunction

    // Mostly well-formed operands of varied length; the rest zero divisors,
    // single bad nibbles and raw bit patterns.
    function automatic bld_req_t pick_operands();
        bld_req_t op;
        int       sel;
        int       dvd_digits;
        int       pos;
        sel        = $urandom_range(99);
        dvd_digits = ($urandom_range(3) == 0) ? $urandom_range(0, DIVIDEND_W / 4)
                                              : DIVIDEND_W / 4;
        op.dividend_bcd = rand_bcd(dvd_digits);
        op.divisor_bcd  = DIVISOR_W'(rand_bcd($urandom_range(1, DIVISOR_W / 4)));
        if (sel < 78)
        begin
            if (op.divisor_bcd == '0)
                op.divisor_bcd[3:0] = 4'($urandom_range(1, 9));
        end
        else if (sel < 86)
            op.divisor_bcd = '0;
        else if (sel < 95)
        begin
            if ($urandom_range(1) == 0)
            begin
                pos = $urandom_range(DIVIDEND_W / 4 - 1);
                op.dividend_bcd[4*pos +: 4] = 4'($urandom_range(10, 15));
            end
            else
            begin
                pos = $urandom_range(DIVISOR_W / 4 - 1);
                op.divisor_bcd[4*pos +: 4] = 4'($urandom_range(10, 15));
            end
        end
        else
        begin
            op.dividend_bcd = $urandom;
            op.divisor_bcd  = DIVISOR_W'($urandom);
        end
        return op;
    endfunction

    // Holds the transaction on the channel until the divider takes it.
    task automatic offer_item(input bld_req_t op);
        req_valid <= 1'b1;
        req       <= op;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            req_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int       sent;
        int       burst;
        int       gap;
        bit       drained;
        bld_req_t directed_ops[$];
        clk       = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        long_hold = 1'b0;
        sent      = 0;
        drained   = 1'b0;
        directed_ops = '{
            operands(32'h0000_0000, 16'h0001),
            operands(32'h9999_9999, 16'h0001),
            operands(32'h9999_9999, 16'h9999),
            operands(32'h0000_0000, 16'h9999),
            operands(32'h1234_5678, 16'h0007),
            operands(32'h0000_9998, 16'h9999),
            operands(32'h0000_9999, 16'h9999),
            operands(32'h9999_9999, 16'h0000),
            operands(32'h0000_0000, 16'h0000),
            operands(32'hA000_0000, 16'h0001),
            operands(32'h0000_000F, 16'h0001),
            operands(32'h1234_5678, 16'h000A),
            operands(32'h1234_5678, 16'hF000),
            operands(32'hFFFF_FFFF, 16'hFFFF),
            operands(32'h0000_000A, 16'h0000),
            operands(32'h9876_5432, 16'h0009),
            operands(32'h9999_9999, 16'h0002),
            operands(32'h1000_0000, 16'h3333),
            operands(32'h5555_5555, 16'h5555),
            operands(32'h9000_0000, 16'h0001)
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_ops[i])
        begin
            offer_item(directed_ops[i]);
            pause_sender($urandom_range(0, 3));
        end
        wait_drained();

        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++)
            begin
                offer_item(pick_operands());
                sent++;
                if (sent == 150)
                    long_hold <= 1'b1;
            end
            if (sent >= 400 && !drained)
            begin
                drained = 1'b1;
                wait_drained();
            end
            else
            begin
                case ($urandom_range(7))
                    0, 1:    gap = 0;
                    6:       gap = $urandom_range(20, 60);
                    7:       gap = $urandom_range(60, 120);
                    default: gap = $urandom_range(1, 8);
                endcase
                pause_sender(gap);
            end
        end

        wait_drained();
        repeat (120) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Result side: segments of steady, random and sparse acceptance, plus one
    // long hold-off once the sender is well into the random traffic.
    initial
    begin
        int mode;
        int seg_len;
        bit hold_done;
        rsp_ready = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            if (long_hold && !hold_done)
            begin
                hold_done = 1'b1;
                rsp_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else
            begin
                mode    = $urandom_range(2);
                seg_len = $urandom_range(10, 150);
                repeat (seg_len)
                begin
                    case (mode)
                        0:       rsp_ready <= 1'b1;
                        1:       rsp_ready <= 1'($urandom_range(1));
                        default: rsp_ready <= ($urandom_range(5) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
